// File: hw/rtl/mctc_pkg.sv
// Shared widths, status codes and sideband types for the circle time-of-impact pipeline.
package mctc_pkg;

   // field and intermediate widths
   localparam int IN_W      = 32;
   localparam int MAG_W     = IN_W + 1;            // |difference| of two Q16.16 values
   localparam int PROD_W    = 2 * MAG_W;           // squares, dot terms, a, c, |b|
   localparam int LIMB_W    = MAG_W;               // limb for wide products
   localparam int WIDE_W    = 2 * PROD_W;          // b*b and a*c before trimming
   localparam int RAD_W     = WIDE_W - 1;          // discriminant
   localparam int TRIAL_W   = RAD_W + 2;           // square-root trial value
   localparam int ROOT_W    = PROD_W;              // square root of discriminant
   localparam int TIME_W    = 32;                  // impact time, unsigned Q16.16
   localparam int FRAC_W    = 16;                  // fraction bits of Q16.16
   localparam int NUM_W     = PROD_W + FRAC_W;     // dividend
   localparam int DIV_CMP_W = PROD_W + TIME_W;     // divisor shifted by a quotient bit
   localparam int STATUS_W  = 2;

   localparam logic [IN_W-1:0] RADIUS_RESET = 32'h0001_0000;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE    = 2'd0,
      STATUS_OVERLAP = 2'd1,
      STATUS_FUTURE  = 2'd2
   } status_type;

   // early decision that rides along with each transaction
   typedef struct packed {
      logic overlap;   // touching or overlapping now
      logic dead;      // no future contact
   } verdict_type;

   // what travels beside the square-root pipeline
   typedef struct packed {
      logic [PROD_W-1:0] bm;    // -b, positive when approaching
      logic [PROD_W-1:0] den;   // a = |v|^2
      verdict_type       verdict;
   } sqrt_side_type;

endpackage

// File: hw/rtl/mctc_isqrt_pipe.sv
// Fully pipelined integer square root, one result bit per stage.
module mctc_isqrt_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [mctc_pkg::RAD_W-1:0]    in_radicand,
   input  mctc_pkg::sqrt_side_type       in_side,
   output logic                          out_valid,
   output logic [mctc_pkg::ROOT_W-1:0]   out_root,
   output mctc_pkg::sqrt_side_type       out_side
);
   import mctc_pkg::*;

   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   sqrt_side_type     side_ff [ROOT_W];
   logic [ROOT_W-1:0] valid_ff;

   genvar s;
   for (s = 0; s < ROOT_W; s++) begin : g_stage
      localparam int K = ROOT_W - 1 - s;
      logic [RAD_W-1:0]   rem_cur;
      logic [ROOT_W-1:0]  root_cur;
      sqrt_side_type      side_cur;
      logic               valid_cur;
      logic [TRIAL_W-1:0] trial;
      logic               fits;

      if (s == 0) begin : g_first
         assign rem_cur   = in_radicand;
         assign root_cur  = '0;
         assign side_cur  = in_side;
         assign valid_cur = in_valid;
      end else begin : g_next
         assign rem_cur   = rem_ff[s-1];
         assign root_cur  = root_ff[s-1];
         assign side_cur  = side_ff[s-1];
         assign valid_cur = valid_ff[s-1];
      end

      // setting bit K adds (root << (K+1)) + 2^(2K) to root squared
      assign trial = (TRIAL_W'(root_cur) << (K + 1)) | (TRIAL_W'(1) << (2 * K));
      assign fits  = TRIAL_W'(rem_cur) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= fits ? (rem_cur - trial[RAD_W-1:0]) : rem_cur;
         root_ff[s] <= fits ? (root_cur | (ROOT_W'(1) << K)) : root_cur;
         side_ff[s] <= side_cur;
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// File: hw/rtl/mctc_div_pipe.sv
// Fully pipelined restoring divider with a 32-bit quotient and a saturation flag.
module mctc_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [mctc_pkg::NUM_W-1:0]    in_num,
   input  logic [mctc_pkg::PROD_W-1:0]   in_den,
   input  mctc_pkg::verdict_type         in_verdict,
   output logic                          out_valid,
   output logic [mctc_pkg::TIME_W-1:0]   out_quot,
   output logic                          out_sat,
   output mctc_pkg::verdict_type         out_verdict
);
   import mctc_pkg::*;

   logic [NUM_W-1:0]  rem_ff     [TIME_W];
   logic [PROD_W-1:0] den_ff     [TIME_W];
   logic [TIME_W-1:0] quot_ff    [TIME_W];
   verdict_type       verdict_ff [TIME_W];
   logic [TIME_W-1:0] sat_ff;
   logic [TIME_W-1:0] valid_ff;

   genvar s;
   for (s = 0; s < TIME_W; s++) begin : g_stage
      localparam int J = TIME_W - 1 - s;
      logic [NUM_W-1:0]     rem_cur;
      logic [PROD_W-1:0]    den_cur;
      logic [TIME_W-1:0]    quot_cur;
      verdict_type          verdict_cur;
      logic                 sat_cur;
      logic                 valid_cur;
      logic [DIV_CMP_W-1:0] trial;
      logic                 fits;

      if (s == 0) begin : g_first
         assign rem_cur     = in_num;
         assign den_cur     = in_den;
         assign quot_cur    = '0;
         assign verdict_cur = in_verdict;
         // quotient would not fit in 32 bits
         assign sat_cur     = DIV_CMP_W'(in_num) >= (DIV_CMP_W'(in_den) << TIME_W);
         assign valid_cur   = in_valid;
      end else begin : g_next
         assign rem_cur     = rem_ff[s-1];
         assign den_cur     = den_ff[s-1];
         assign quot_cur    = quot_ff[s-1];
         assign verdict_cur = verdict_ff[s-1];
         assign sat_cur     = sat_ff[s-1];
         assign valid_cur   = valid_ff[s-1];
      end

      assign trial = DIV_CMP_W'(den_cur) << J;
      assign fits  = DIV_CMP_W'(rem_cur) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]     <= fits ? (rem_cur - trial[NUM_W-1:0]) : rem_cur;
         quot_ff[s]    <= fits ? (quot_cur | (TIME_W'(1) << J)) : quot_cur;
         den_ff[s]     <= den_cur;
         verdict_ff[s] <= verdict_cur;
         sat_ff[s]     <= sat_cur;
      end
   end

   assign out_valid   = valid_ff[TIME_W-1];
   assign out_quot    = quot_ff[TIME_W-1];
   assign out_sat     = sat_ff[TIME_W-1];
   assign out_verdict = verdict_ff[TIME_W-1];

endmodule

// File: hw/rtl/moving_circle_time_to_collision.sv
// Top level: time of impact of two moving circles, one pair per cycle.
//
// Takes one circle pair per clock whenever start is high; busy is always low.
// Each transaction produces exactly one result, strobed on rsp_valid for one
// cycle. It passes through seven front stages for differences, squares, the
// wide products and the discriminant, a 66-stage square root, one subtract
// stage, a 32-stage divider and the output register. The result side has no
// back-pressure, so the receiver must capture every strobe. The combined
// radius register must only be written while no transaction is in flight.
module moving_circle_time_to_collision (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_first_pos_x,
   input  logic [31:0] req_first_pos_y,
   input  logic [31:0] req_first_vel_x,
   input  logic [31:0] req_first_vel_y,
   input  logic [31:0] req_second_pos_x,
   input  logic [31:0] req_second_pos_y,
   input  logic [31:0] req_second_vel_x,
   input  logic [31:0] req_second_vel_y,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_impact_time,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import mctc_pkg::*;

   localparam int FRONT_STAGES = 7;
   localparam int LATENCY      = FRONT_STAGES + ROOT_W + 1 + TIME_W + 1;

   // {negative, magnitude} of hi - lo
   function automatic logic [MAG_W:0] diff_abs(logic [IN_W-1:0] hi, logic [IN_W-1:0] lo);
      logic [MAG_W-1:0] u;
      logic [MAG_W-1:0] m;
      u = {hi[IN_W-1], hi} - {lo[IN_W-1], lo};
      m = u[MAG_W-1] ? (~u + MAG_W'(1)) : u;
      return {u[MAG_W-1], m};
   endfunction

   logic accept;
   assign accept    = start && !busy;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // radius register
   logic [IN_W-1:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_data;
      end
   end

   logic [FRONT_STAGES-1:0] valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[FRONT_STAGES-2:0], accept};
      end
   end

   // stage 0: relative position and velocity magnitudes
   logic [MAG_W:0]   dx_in, dy_in, vx_in, vy_in;
   logic [MAG_W-1:0] dx_ff, dy_ff, vx_ff, vy_ff;
   logic             sx_ff, sy_ff;
   assign dx_in = diff_abs(req_second_pos_x, req_first_pos_x);
   assign dy_in = diff_abs(req_second_pos_y, req_first_pos_y);
   assign vx_in = diff_abs(req_second_vel_x, req_first_vel_x);
   assign vy_in = diff_abs(req_second_vel_y, req_first_vel_y);
   always_ff @(posedge clock) begin
      dx_ff <= dx_in[MAG_W-1:0];
      dy_ff <= dy_in[MAG_W-1:0];
      vx_ff <= vx_in[MAG_W-1:0];
      vy_ff <= vy_in[MAG_W-1:0];
      sx_ff <= dx_in[MAG_W] ^ vx_in[MAG_W];
      sy_ff <= dy_in[MAG_W] ^ vy_in[MAG_W];
   end

   // stage 1: squares and dot terms
   logic [PROD_W-1:0] dxx_ff, dyy_ff, vxx_ff, vyy_ff, dvx_ff, dvy_ff;
   logic [2*IN_W-1:0] rr_ff;
   logic              sx1_ff, sy1_ff;
   always_ff @(posedge clock) begin
      dxx_ff <= dx_ff * dx_ff;
      dyy_ff <= dy_ff * dy_ff;
      vxx_ff <= vx_ff * vx_ff;
      vyy_ff <= vy_ff * vy_ff;
      dvx_ff <= dx_ff * vx_ff;
      dvy_ff <= dy_ff * vy_ff;
      rr_ff  <= radius_ff * radius_ff;
      sx1_ff <= sx_ff;
      sy1_ff <= sy_ff;
   end

   // stage 2: |d|^2, a and the signed parts of b
   logic [PROD_W-1:0] d2_ff, a2_ff, pos_ff, neg_ff;
   logic [2*IN_W-1:0] rr2_ff;
   always_ff @(posedge clock) begin
      d2_ff  <= dxx_ff + dyy_ff;
      a2_ff  <= vxx_ff + vyy_ff;
      pos_ff <= (sx1_ff ? '0 : dvx_ff) + (sy1_ff ? '0 : dvy_ff);
      neg_ff <= (sx1_ff ? dvx_ff : '0) + (sy1_ff ? dvy_ff : '0);
      rr2_ff <= rr_ff;
   end

   // stage 3: c, -b and early outcomes
   logic [PROD_W-1:0] c3_ff, a3_ff, bm3_ff;
   verdict_type       verdict3_ff;
   always_ff @(posedge clock) begin
      c3_ff               <= d2_ff - PROD_W'(rr2_ff);
      a3_ff               <= a2_ff;
      bm3_ff              <= neg_ff - pos_ff;
      verdict3_ff.overlap <= d2_ff <= PROD_W'(rr2_ff);
      verdict3_ff.dead    <= (a2_ff == '0) || (neg_ff <= pos_ff);
   end

   // stage 4: limb products of b*b and a*c
   logic [PROD_W-1:0] bll_ff, blh_ff, bhh_ff, all_ff, alh_ff, ahl_ff, ahh_ff;
   logic [PROD_W-1:0] a4_ff, bm4_ff;
   verdict_type       verdict4_ff;
   always_ff @(posedge clock) begin
      bll_ff      <= bm3_ff[LIMB_W-1:0] * bm3_ff[LIMB_W-1:0];
      blh_ff      <= bm3_ff[LIMB_W-1:0] * bm3_ff[PROD_W-1:LIMB_W];
      bhh_ff      <= bm3_ff[PROD_W-1:LIMB_W] * bm3_ff[PROD_W-1:LIMB_W];
      all_ff      <= a3_ff[LIMB_W-1:0] * c3_ff[LIMB_W-1:0];
      alh_ff      <= a3_ff[LIMB_W-1:0] * c3_ff[PROD_W-1:LIMB_W];
      ahl_ff      <= a3_ff[PROD_W-1:LIMB_W] * c3_ff[LIMB_W-1:0];
      ahh_ff      <= a3_ff[PROD_W-1:LIMB_W] * c3_ff[PROD_W-1:LIMB_W];
      a4_ff       <= a3_ff;
      bm4_ff      <= bm3_ff;
      verdict4_ff <= verdict3_ff;
   end

   // stage 5: assemble b*b and a*c
   logic [WIDE_W-1:0] bb_ff, ac_ff;
   logic [PROD_W-1:0] a5_ff, bm5_ff;
   verdict_type       verdict5_ff;
   always_ff @(posedge clock) begin
      bb_ff <= (WIDE_W'(bhh_ff) << (2 * LIMB_W)) + (WIDE_W'(blh_ff) << (LIMB_W + 1))
               + WIDE_W'(bll_ff);
      ac_ff <= (WIDE_W'(ahh_ff) << (2 * LIMB_W)) + (WIDE_W'(alh_ff) << LIMB_W)
               + (WIDE_W'(ahl_ff) << LIMB_W) + WIDE_W'(all_ff);
      a5_ff       <= a4_ff;
      bm5_ff      <= bm4_ff;
      verdict5_ff <= verdict4_ff;
   end

   // stage 6: discriminant
   logic [WIDE_W-1:0] disc_in;
   logic [RAD_W-1:0]  disc_ff;
   sqrt_side_type     side6_ff;
   assign disc_in = bb_ff - ac_ff;
   always_ff @(posedge clock) begin
      disc_ff                  <= disc_in[RAD_W-1:0];
      side6_ff.bm              <= bm5_ff;
      side6_ff.den             <= a5_ff;
      side6_ff.verdict.overlap <= verdict5_ff.overlap;
      side6_ff.verdict.dead    <= verdict5_ff.dead || (ac_ff > bb_ff);
   end

   // square root of the discriminant
   logic              root_valid;
   logic [ROOT_W-1:0] root;
   sqrt_side_type     root_side;
   mctc_isqrt_pipe u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (valid_ff[FRONT_STAGES-1]),
      .in_radicand (disc_ff),
      .in_side     (side6_ff),
      .out_valid   (root_valid),
      .out_root    (root),
      .out_side    (root_side)
   );

   // numerator -b - sqrt(disc)
   logic              num_valid_ff;
   logic [PROD_W-1:0] num_ff, den_ff;
   verdict_type       verdict7_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else begin
         num_valid_ff <= root_valid;
      end
   end
   always_ff @(posedge clock) begin
      num_ff      <= root_side.bm - root;
      den_ff      <= root_side.den;
      verdict7_ff <= root_side.verdict;
   end

   // time = numerator * 2^16 / a
   logic              quot_valid;
   logic [TIME_W-1:0] quot;
   logic              quot_sat;
   verdict_type       quot_verdict;
   mctc_div_pipe u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (num_valid_ff),
      .in_num      ({num_ff, FRAC_W'(0)}),
      .in_den      (den_ff),
      .in_verdict  (verdict7_ff),
      .out_valid   (quot_valid),
      .out_quot    (quot),
      .out_sat     (quot_sat),
      .out_verdict (quot_verdict)
   );

   // final status and time
   status_type        status_in;
   logic [TIME_W-1:0] time_in;
   always_comb begin
      priority if (quot_verdict.overlap) begin
         status_in = STATUS_OVERLAP;
      end else if (quot_verdict.dead) begin
         status_in = STATUS_NONE;
      end else begin
         status_in = STATUS_FUTURE;
      end
   end
   assign time_in = (status_in == STATUS_FUTURE) ? (quot_sat ? '1 : quot) : '0;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= quot_valid;
      end
   end
   always_ff @(posedge clock) begin
      rsp_status_ff <= status_in;
      rsp_time_ff   <= time_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_impact_time = rsp_time_ff;

   // every result traces back to a transaction accepted a fixed latency earlier
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without matching transaction");

   // time is only reported for a future collision
   a_time_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_FUTURE)) |-> (rsp_impact_time == '0))
      else $error("nonzero impact time without future collision");

   // an overlap decided early is never turned into a future collision
   a_overlap_kept : assert property (@(posedge clock) disable iff (reset)
      (quot_valid && quot_verdict.overlap) |=> (rsp_status == STATUS_OVERLAP))
      else $error("overlap verdict lost");

endmodule

// File: verif/moving_circle_time_to_collision_tb.sv
// Self-checking testbench for the moving circle time-of-impact pipeline.
module moving_circle_time_to_collision_tb;
   import mctc_pkg::*;

   localparam int LATENCY     = 107;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 10;

   typedef logic [255:0] wide_type;

   typedef struct packed {
      logic [31:0] p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
   } pair_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] impact_time;
   } impact_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   pair_type    pair_drv;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_impact_time;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   impact_type  expected_impacts[$];
   logic [31:0] radius_model;
   int          mismatches;
   int          cycles;
   int          sender_idle_pct;

   moving_circle_time_to_collision i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_pos_x  (pair_drv.p1x),
      .req_first_pos_y  (pair_drv.p1y),
      .req_first_vel_x  (pair_drv.v1x),
      .req_first_vel_y  (pair_drv.v1y),
      .req_second_pos_x (pair_drv.p2x),
      .req_second_pos_y (pair_drv.p2y),
      .req_second_vel_x (pair_drv.v2x),
      .req_second_vel_y (pair_drv.v2y),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_impact_time  (rsp_impact_time),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   // clock: period 4
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // floor square root, bit by bit
   function automatic wide_type floor_sqrt(input wide_type n);
      wide_type res, bt, trial;
      res = '0;
      bt  = wide_type'(1) << 254;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
         trial = res + bt;
         if (n >= trial) begin
            n   = n - trial;
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // magnitude and sign of hi - lo, both signed 32-bit
   function automatic wide_type diff_magnitude(input logic [31:0] hi, input logic [31:0] lo,
                                               output logic negative);
      logic signed [33:0] d;
      d = $signed({{2{hi[31]}}, hi}) - $signed({{2{lo[31]}}, lo});
      negative = d < 0;
      return wide_type'(negative ? -d : d);
   endfunction

   // earliest contact time of one circle pair under the given combined radius
   function automatic impact_type predict_impact(input pair_type p, input logic [31:0] radius);
      impact_type res;
      wide_type   dx, dy, vx, vy, d2, r2, c, a, pos, neg, bm, bb, ac, s, t;
      logic       ndx, ndy, nvx, nvy;
      res = '{STATUS_NONE, 32'd0};
      dx  = diff_magnitude(p.p2x, p.p1x, ndx);
      dy  = diff_magnitude(p.p2y, p.p1y, ndy);
      vx  = diff_magnitude(p.v2x, p.v1x, nvx);
      vy  = diff_magnitude(p.v2y, p.v1y, nvy);
      d2  = dx * dx + dy * dy;
      r2  = wide_type'(radius) * wide_type'(radius);
      if (d2 <= r2) begin
         res.status = STATUS_OVERLAP;
         return res;
      end
      c = d2 - r2;
      a = vx * vx + vy * vy;
      if (a == 0) return res;
      pos = '0;
      neg = '0;
      if (ndx != nvx) neg += dx * vx; else pos += dx * vx;
      if (ndy != nvy) neg += dy * vy; else pos += dy * vy;
      if (neg <= pos) return res;
      bm = neg - pos;
      bb = bm * bm;
      ac = a * c;
      if (ac > bb) return res;
      s = floor_sqrt(bb - ac);
      t = ((bm - s) << 16) / a;
      res.status      = STATUS_FUTURE;
      res.impact_time = (t >> 32) != 0 ? 32'hFFFF_FFFF : t[31:0];
      return res;
   endfunction

   // accept transactions, track the radius, check results
   always @(posedge clock) begin
      impact_type want;
      if (reset) begin
         radius_model = RADIUS_RESET;
      end else begin
         if (rsp_valid) begin
            if (expected_impacts.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: status %0d time %h", rsp_status, rsp_impact_time);
            end else begin
               want = expected_impacts.pop_front();
               if (rsp_status !== want.status || rsp_impact_time !== want.impact_time) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: status exp %0d got %0d, time exp %h got %h",
                              want.status, rsp_status, want.impact_time, rsp_impact_time);
               end
            end
         end
         if (start && !busy)
            expected_impacts = {expected_impacts, predict_impact(pair_drv, radius_model)};
         if (csr_valid && csr_ready) radius_model = csr_data;
      end
   end

   // send one circle pair, idling at random first
   task automatic send_pair(input pair_type p);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      pair_drv <= p;
      do @(posedge clock); while (busy);
   endtask

   task automatic stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // hold off until every expected result has arrived
   task automatic drain();
      while (expected_impacts.size() != 0) @(posedge clock);
   endtask

   task automatic write_radius(input logic [31:0] value);
      stop_sending();
      drain();
      repeat (LATENCY + 3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // random value of random width, sign extended
   function automatic logic [31:0] rand_field();
      logic signed [31:0] v;
      int k;
      k = $urandom_range(32, 1);
      v = $signed($urandom << (32 - k)) >>> (32 - k);
      return v;
   endfunction

   // closing pair: second circle placed off the first, heading roughly back at it
   function automatic pair_type approach_pair();
      pair_type p;
      logic signed [31:0] ox, oy;
      int sh;
      sh    = $urandom_range(8);
      ox    = $signed($urandom << 8) >>> $urandom_range(31, 8);
      oy    = $signed($urandom << 8) >>> $urandom_range(31, 8);
      p.p1x = rand_field() >>> 4;
      p.p1y = rand_field() >>> 4;
      p.v1x = rand_field() >>> 4;
      p.v1y = rand_field() >>> 4;
      p.p2x = p.p1x + ox;
      p.p2y = p.p1y + oy;
      p.v2x = p.v1x - (ox >>> sh) + (rand_field() >>> 12);
      p.v2y = p.v1y - (oy >>> sh) + (rand_field() >>> 12);
      return p;
   endfunction

   function automatic pair_type noise_pair();
      pair_type p;
      if ($urandom_range(1)) p = {$urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom};
      else p = {rand_field(), rand_field(), rand_field(), rand_field(),
                rand_field(), rand_field(), rand_field(), rand_field()};
      return p;
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_pair($urandom_range(99) < 70 ? approach_pair() : noise_pair());
   endtask

   // extremes of every field and each outcome
   task automatic test_directed();
      localparam logic [31:0] MN = 32'h8000_0000;
      localparam logic [31:0] MX = 32'h7FFF_FFFF;
      localparam logic [31:0] ONE = 32'h0001_0000;
      send_pair('{0, 0, 0, 0, 0, 0, 0, 0});                                // coincident
      send_pair('{0, 0, 0, 0, ONE, 0, 0, 0});                              // touching
      send_pair('{MN, MN, 0, 0, MX, MX, 0, 0});                            // at rest
      send_pair('{0, 0, 0, 0, 10 * ONE, 0, -ONE, 0});                      // head on
      send_pair('{0, 0, 0, 0, 10 * ONE, 0, ONE, 0});                       // moving apart
      send_pair('{0, 0, 0, 0, 10 * ONE, 0, 0, ONE});                       // tangent motion
      send_pair('{0, 0, 0, 0, 10 * ONE, 5 * ONE, -ONE, 0});                // near miss
      send_pair('{0, 0, 0, 0, 10 * ONE, 2 * ONE, -ONE, 0});                // glancing
      send_pair('{MN, 0, 0, 0, MX, 0, 32'hFFFF_FFFF, 0});                  // far future
      send_pair('{MN, MN, MX, MX, MX, MX, MN, MN});                        // extreme approach
      send_pair('{MX, MX, MN, MN, MN, MN, MX, MX});                        // extreme, other way
      send_pair('{MX, MN, MX, MN, MN, MX, MN, MX});
      send_pair('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  0, 0, 0, 0});
      send_pair('{0, 0, 0, 0, 3 * ONE, 4 * ONE, -3, -4});                  // slow, saturating at zero radius
      stop_sending();
   endtask

   task automatic test_radius_extremes();
      write_radius(32'd0);
      test_directed();
      write_radius(32'hFFFF_FFFF);
      test_directed();
      send_random(30);
      write_radius(32'd1);
      send_random(30);
      stop_sending();
   endtask

   task automatic test_random_phases();
      write_radius(32'h0001_0000);
      sender_idle_pct = 35;
      send_random(350);
      stop_sending();
      drain();
      sender_idle_pct = 65;
      send_random(350);
      write_radius($urandom >> $urandom_range(20, 8));
      sender_idle_pct = 0;
      send_random(300);
      stop_sending();
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      pair_drv        = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      sender_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_radius_extremes();
      test_random_phases();

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_impacts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/mctc_pkg.sv
hw/rtl/mctc_isqrt_pipe.sv
hw/rtl/mctc_div_pipe.sv
hw/rtl/moving_circle_time_to_collision.sv
verif/moving_circle_time_to_collision_tb.sv
